/* sv/ps2mct_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mct_pkg
// shared types and constants of the ps/2 mouse cursor tracker
// ----------------------------------------------------------------------------
package ps2mct_pkg;

  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned REG_BITS       = 12;
  localparam int unsigned CFG_ADDR_BITS  = 2;
  localparam int unsigned IN_TDATA_BITS  = 40;
  localparam int unsigned OUT_TDATA_BITS = 32;
  localparam int unsigned OUT_TUSER_BITS = 2;

  localparam int unsigned POS_X_RESET = 40;
  localparam int unsigned POS_Y_RESET = 12;
  localparam logic [REG_BITS-1:0] X_MIN_RESET = 12'd0;
  localparam logic [REG_BITS-1:0] X_MAX_RESET = 12'd79;
  localparam logic [REG_BITS-1:0] Y_MIN_RESET = 12'd0;
  localparam logic [REG_BITS-1:0] Y_MAX_RESET = 12'd24;

  // flags byte layout
  localparam int unsigned SYNC_BIT   = 3;
  localparam int unsigned X_SIGN_BIT = 4;
  localparam int unsigned Y_SIGN_BIT = 5;
  localparam int unsigned X_OVF_BIT  = 6;
  localparam int unsigned Y_OVF_BIT  = 7;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_X_MIN = 2'd0,
    REG_X_MAX = 2'd1,
    REG_Y_MIN = 2'd2,
    REG_Y_MAX = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    PH_FLAGS = 3'b001,
    PH_DX    = 3'b010,
    PH_DY    = 3'b100
  } phase_e;

  typedef struct packed {
    logic                kind;
    logic [7:0]          data_byte;
    logic                from_aux;
    logic [REG_BITS-1:0] new_x;
    logic [REG_BITS-1:0] new_y;
  } item_t;

  typedef struct packed {
    logic [REG_BITS-1:0] x_min;
    logic [REG_BITS-1:0] x_max;
    logic [REG_BITS-1:0] y_min;
    logic [REG_BITS-1:0] y_max;
  } bounds_t;

  typedef struct packed {
    logic [REG_BITS-1:0] cursor_x;
    logic [REG_BITS-1:0] cursor_y;
    logic                left_pressed;
    logic                right_pressed;
    logic                middle_pressed;
    logic                packet_applied;
    logic                packet_dropped;
  } result_t;

endpackage

/* sv/ps2mct_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mct_cfg
// cursor bound registers, written over the configuration channel
// ----------------------------------------------------------------------------
module ps2mct_cfg (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_valid_i,
  input  logic [ps2mct_pkg::CFG_ADDR_BITS-1:0]    cfg_addr_i,
  input  logic [ps2mct_pkg::REG_BITS-1:0]         cfg_data_i,
  output ps2mct_pkg::bounds_t                     bounds_o
);

  ps2mct_pkg::bounds_t bounds_q, bounds_d;

  always_comb begin
    bounds_d = bounds_q;
    if (cfg_valid_i) begin
      case (ps2mct_pkg::cfg_reg_e'(cfg_addr_i))
        ps2mct_pkg::REG_X_MIN: bounds_d.x_min = cfg_data_i;
        ps2mct_pkg::REG_X_MAX: bounds_d.x_max = cfg_data_i;
        ps2mct_pkg::REG_Y_MIN: bounds_d.y_min = cfg_data_i;
        ps2mct_pkg::REG_Y_MAX: bounds_d.y_max = cfg_data_i;
        default: bounds_d = bounds_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bounds_q.x_min <= ps2mct_pkg::X_MIN_RESET;
      bounds_q.x_max <= ps2mct_pkg::X_MAX_RESET;
      bounds_q.y_min <= ps2mct_pkg::Y_MIN_RESET;
      bounds_q.y_max <= ps2mct_pkg::Y_MAX_RESET;
    end else begin
      bounds_q <= bounds_d;
    end
  end

  assign bounds_o = bounds_q;

endmodule

/* sv/ps2mct_in_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mct_in_reg
// input register, holds one accepted item until the result stage takes it
// ----------------------------------------------------------------------------
module ps2mct_in_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ps2mct_pkg::item_t   in_item_i,
  output logic                item_valid_o,
  input  logic                item_take_i,
  output ps2mct_pkg::item_t   item_o
);

  logic              valid_q, valid_d;
  ps2mct_pkg::item_t item_q;

  assign in_ready_o = !valid_q || item_take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

/* sv/ps2mct_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mct_core
// packet framing, delta accumulation and clamping for one item per cycle, when step_i is set
// ----------------------------------------------------------------------------
module ps2mct_core #(
  parameter int unsigned COORD_BITS = ps2mct_pkg::COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  ps2mct_pkg::item_t     item_i,
  input  ps2mct_pkg::bounds_t   bounds_i,
  output ps2mct_pkg::result_t   result_o
);

  localparam int unsigned WIDE = ps2mct_pkg::REG_BITS > COORD_BITS ?
                                 ps2mct_pkg::REG_BITS : COORD_BITS;
  localparam int unsigned SW   = WIDE + 2;

  ps2mct_pkg::phase_e    phase_q, phase_d;
  logic [7:0]            flags_q, flags_d;
  logic [7:0]            dx_q, dx_d;
  logic [COORD_BITS-1:0] pos_x_q, pos_x_d;
  logic [COORD_BITS-1:0] pos_y_q, pos_y_d;
  logic [2:0]            buttons_q, buttons_d;
  logic                  applied, dropped;

  logic signed [SW-1:0]  dx_s, dy_s, cand_x, cand_y;
  logic [COORD_BITS-1:0] clamp_x, clamp_y;

  function automatic logic [COORD_BITS-1:0] clamp_fn(
    input logic signed [SW-1:0]             v,
    input logic [ps2mct_pkg::REG_BITS-1:0]  lo,
    input logic [ps2mct_pkg::REG_BITS-1:0]  hi
  );
    logic signed [SW-1:0] lo_s;
    logic signed [SW-1:0] hi_s;
    logic signed [SW-1:0] r;
    lo_s = signed'(SW'(lo));
    hi_s = signed'(SW'(hi));
    r    = v;
    if (r < lo_s) r = lo_s;
    if (r > hi_s) r = hi_s;
    return COORD_BITS'(r);
  endfunction

  always_comb begin
    dx_s = signed'({{(SW-8){flags_q[ps2mct_pkg::X_SIGN_BIT]}}, dx_q});
    dy_s = signed'({{(SW-8){flags_q[ps2mct_pkg::Y_SIGN_BIT]}}, item_i.data_byte});
    if (item_i.kind) begin
      cand_x = signed'(SW'(item_i.new_x));
      cand_y = signed'(SW'(item_i.new_y));
    end else begin
      cand_x = signed'(SW'(pos_x_q)) + dx_s;
      cand_y = signed'(SW'(pos_y_q)) - dy_s;
    end
    clamp_x = clamp_fn(cand_x, bounds_i.x_min, bounds_i.x_max);
    clamp_y = clamp_fn(cand_y, bounds_i.y_min, bounds_i.y_max);
  end

  always_comb begin
    phase_d   = phase_q;
    flags_d   = flags_q;
    dx_d      = dx_q;
    pos_x_d   = pos_x_q;
    pos_y_d   = pos_y_q;
    buttons_d = buttons_q;
    applied   = 1'b0;
    dropped   = 1'b0;
    if (item_i.kind) begin
      pos_x_d = clamp_x;
      pos_y_d = clamp_y;
      phase_d = ps2mct_pkg::PH_FLAGS;
    end else if (item_i.from_aux) begin
      case (phase_q)
        ps2mct_pkg::PH_DX: begin
          dx_d    = item_i.data_byte;
          phase_d = ps2mct_pkg::PH_DY;
        end
        ps2mct_pkg::PH_DY: begin
          phase_d = ps2mct_pkg::PH_FLAGS;
          if (flags_q[ps2mct_pkg::X_OVF_BIT] || flags_q[ps2mct_pkg::Y_OVF_BIT]) begin
            dropped = 1'b1;
          end else begin
            buttons_d = flags_q[2:0];
            pos_x_d   = clamp_x;
            pos_y_d   = clamp_y;
            applied   = 1'b1;
          end
        end
        default: begin
          if (item_i.data_byte[ps2mct_pkg::SYNC_BIT]) begin
            flags_d = item_i.data_byte;
            phase_d = ps2mct_pkg::PH_DX;
          end else begin
            phase_d = ps2mct_pkg::PH_FLAGS;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= ps2mct_pkg::PH_FLAGS;
      flags_q   <= 8'd0;
      dx_q      <= 8'd0;
      pos_x_q   <= COORD_BITS'(ps2mct_pkg::POS_X_RESET);
      pos_y_q   <= COORD_BITS'(ps2mct_pkg::POS_Y_RESET);
      buttons_q <= 3'd0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      flags_q   <= flags_d;
      dx_q      <= dx_d;
      pos_x_q   <= pos_x_d;
      pos_y_q   <= pos_y_d;
      buttons_q <= buttons_d;
    end
  end

  always_comb begin
    result_o.cursor_x       = ps2mct_pkg::REG_BITS'(pos_x_d);
    result_o.cursor_y       = ps2mct_pkg::REG_BITS'(pos_y_d);
    result_o.left_pressed   = buttons_d[0];
    result_o.right_pressed  = buttons_d[1];
    result_o.middle_pressed = buttons_d[2];
    result_o.packet_applied = applied;
    result_o.packet_dropped = dropped;
  end

endmodule

/* sv/ps2mct_out_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mct_out_reg
// result register, holds one result until the downstream transfer
// ----------------------------------------------------------------------------
module ps2mct_out_reg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  res_valid_i,
  output logic                  res_take_o,
  input  ps2mct_pkg::result_t   res_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ps2mct_pkg::result_t   out_o
);

  logic                valid_q, valid_d;
  ps2mct_pkg::result_t res_q;
  logic                free;

  assign free       = !valid_q || out_ready_i;
  assign res_take_o = free && res_valid_i;

  always_comb begin
    valid_d = valid_q;
    if (free) begin
      valid_d = res_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take_o) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = res_q;

endmodule

/* sv/ps2_mouse_cursor_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_mouse_cursor_tracker
// frames 3-byte ps/2 mouse packets and tracks a clamped cursor
// ----------------------------------------------------------------------------
// Takes one item per clock cycle, back to back, and returns one result per
// item. There are two registers: an input register and a result register with
// the framing, add and clamp logic between them. Input stalls only when
// the result register is full and not taken. Bound registers take effect on
// the next clamp; write them only while no item is in flight.
// ----------------------------------------------------------------------------
module ps2_mouse_cursor_tracker #(
  parameter int unsigned COORD_BITS = ps2mct_pkg::COORD_BITS_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // data_byte[7:0], from_aux[8], new_x[20:9], new_y[32:21], zero pad
  input  logic [ps2mct_pkg::IN_TDATA_BITS-1:0]       s_axis_tdata,
  // kind[0]
  input  logic                                       s_axis_tuser,
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  // cursor_x[11:0], cursor_y[23:12], left[24], right[25], middle[26], zero pad
  output logic [ps2mct_pkg::OUT_TDATA_BITS-1:0]      m_axis_tdata,
  // packet_applied[0], packet_dropped[1]
  output logic [ps2mct_pkg::OUT_TUSER_BITS-1:0]      m_axis_tuser,
  input  logic                                       cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  logic [ps2mct_pkg::CFG_ADDR_BITS-1:0]       cfg_addr_i,
  input  logic [ps2mct_pkg::REG_BITS-1:0]            cfg_data_i
);

  localparam int unsigned RB = ps2mct_pkg::REG_BITS;

  ps2mct_pkg::item_t   in_item, item;
  ps2mct_pkg::bounds_t bounds;
  ps2mct_pkg::result_t result, out_res;
  logic                item_valid;
  logic                take;

  always_comb begin
    in_item.kind      = s_axis_tuser;
    in_item.data_byte = s_axis_tdata[7:0];
    in_item.from_aux  = s_axis_tdata[8];
    in_item.new_x     = s_axis_tdata[9 +: RB];
    in_item.new_y     = s_axis_tdata[9 + RB +: RB];
  end

  assign cfg_ready_o = 1'b1;

  ps2mct_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .bounds_o    (bounds)
  );

  ps2mct_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (in_item),
    .item_valid_o (item_valid),
    .item_take_i  (take),
    .item_o       (item)
  );

  ps2mct_core #(
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (take),
    .item_i   (item),
    .bounds_i (bounds),
    .result_o (result)
  );

  ps2mct_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (item_valid),
    .res_take_o  (take),
    .res_i       (result),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (out_res)
  );

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[0 +: RB]  = out_res.cursor_x;
    m_axis_tdata[RB +: RB] = out_res.cursor_y;
    m_axis_tdata[2*RB]     = out_res.left_pressed;
    m_axis_tdata[2*RB + 1] = out_res.right_pressed;
    m_axis_tdata[2*RB + 2] = out_res.middle_pressed;
    m_axis_tuser[0]        = out_res.packet_applied;
    m_axis_tuser[1]        = out_res.packet_dropped;
  end

endmodule

/* sv/ps2mct_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mct_checker
// port level checks of the cursor tracker, bound to the top level
// ----------------------------------------------------------------------------
module ps2mct_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  s_axis_tready,
  input logic                                  m_axis_tvalid,
  input logic                                  m_axis_tready,
  input logic [ps2mct_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
  input logic [ps2mct_pkg::OUT_TUSER_BITS-1:0] m_axis_tuser
);

  // output held while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn before transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed before transfer");

  // input only backs up when the result register is full and stalled
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled with free result register");

  // a packet is either applied or dropped, never both
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("packet both applied and dropped");

endmodule

bind ps2_mouse_cursor_tracker ps2mct_checker u_ps2mct_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the ps/2 mouse cursor tracker
// ----------------------------------------------------------------------------
// Drives controller bytes and set-position items on the input stream and
// bound writes on the config channel. A scoreboard class keeps its own
// copy of the framing, button and cursor state, predicts one result per
// accepted item and compares every returned result field by field.
// Traffic is mostly well-formed packets with random deltas and buttons,
// mixed with overflow packets, foreign-port bytes, unsynced bytes and
// set-position items that cut packets short. Both sides stall at random.
// The run covers the reset bounds, full range, inverted bounds, single-point
// bounds and random bounds.
// ----------------------------------------------------------------------------

class cursor_scoreboard;
  ps2mct_pkg::bounds_t bnd;
  ps2mct_pkg::phase_e  phase;
  logic [7:0]          flags_q;
  logic [7:0]          dx_q;
  logic [11:0]         pos_x;
  logic [11:0]         pos_y;
  logic [2:0]          buttons;
  ps2mct_pkg::result_t expected_q[$];
  int                  errors;

  function new();
    bnd.x_min = ps2mct_pkg::X_MIN_RESET;
    bnd.x_max = ps2mct_pkg::X_MAX_RESET;
    bnd.y_min = ps2mct_pkg::Y_MIN_RESET;
    bnd.y_max = ps2mct_pkg::Y_MAX_RESET;
    phase     = ps2mct_pkg::PH_FLAGS;
    flags_q   = '0;
    dx_q      = '0;
    pos_x     = 12'(ps2mct_pkg::POS_X_RESET);
    pos_y     = 12'(ps2mct_pkg::POS_Y_RESET);
    buttons   = '0;
    errors    = 0;
  endfunction

  function void write_reg(ps2mct_pkg::cfg_reg_e r, logic [11:0] v);
    case (r)
      ps2mct_pkg::REG_X_MIN: bnd.x_min = v;
      ps2mct_pkg::REG_X_MAX: bnd.x_max = v;
      ps2mct_pkg::REG_Y_MIN: bnd.y_min = v;
      ps2mct_pkg::REG_Y_MAX: bnd.y_max = v;
      default: ;
    endcase
  endfunction

  // minimum first, then maximum, so inverted bounds end at the maximum
  function logic [11:0] clamp(int v, int lo, int hi);
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v[11:0];
  endfunction

  function void note_item(ps2mct_pkg::item_t it);
    ps2mct_pkg::result_t r;
    int dx;
    int dy;
    r = '0;
    if (it.kind) begin
      pos_x = clamp(int'(it.new_x), int'(bnd.x_min), int'(bnd.x_max));
      pos_y = clamp(int'(it.new_y), int'(bnd.y_min), int'(bnd.y_max));
      phase = ps2mct_pkg::PH_FLAGS;
    end else if (it.from_aux) begin
      case (phase)
        ps2mct_pkg::PH_DX: begin
          dx_q  = it.data_byte;
          phase = ps2mct_pkg::PH_DY;
        end
        ps2mct_pkg::PH_DY: begin
          phase = ps2mct_pkg::PH_FLAGS;
          if (flags_q[ps2mct_pkg::X_OVF_BIT] || flags_q[ps2mct_pkg::Y_OVF_BIT]) begin
            r.packet_dropped = 1'b1;
          end else begin
            dx = int'(dx_q) - (flags_q[ps2mct_pkg::X_SIGN_BIT] ? 256 : 0);
            dy = int'(it.data_byte) - (flags_q[ps2mct_pkg::Y_SIGN_BIT] ? 256 : 0);
            buttons = flags_q[2:0];
            pos_x = clamp(int'(pos_x) + dx, int'(bnd.x_min), int'(bnd.x_max));
            pos_y = clamp(int'(pos_y) - dy, int'(bnd.y_min), int'(bnd.y_max));
            r.packet_applied = 1'b1;
          end
        end
        default: begin
          if (it.data_byte[ps2mct_pkg::SYNC_BIT]) begin
            flags_q = it.data_byte;
            phase   = ps2mct_pkg::PH_DX;
          end else begin
            phase = ps2mct_pkg::PH_FLAGS;
          end
        end
      endcase
    end
    r.cursor_x       = pos_x;
    r.cursor_y       = pos_y;
    r.left_pressed   = buttons[0];
    r.right_pressed  = buttons[1];
    r.middle_pressed = buttons[2];
    expected_q.push_back(r);
  endfunction

  function void compare_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  function void check_result(logic [31:0] td, logic [1:0] tu);
    ps2mct_pkg::result_t e;
    if (expected_q.size() == 0) begin
      $error("result transfer with no expectation waiting");
      errors++;
      return;
    end
    e = expected_q.pop_front();
    compare_field("cursor_x", int'(e.cursor_x), int'(td[11:0]));
    compare_field("cursor_y", int'(e.cursor_y), int'(td[23:12]));
    compare_field("left_pressed", int'(e.left_pressed), int'(td[24]));
    compare_field("right_pressed", int'(e.right_pressed), int'(td[25]));
    compare_field("middle_pressed", int'(e.middle_pressed), int'(td[26]));
    compare_field("packet_applied", int'(e.packet_applied), int'(tu[0]));
    compare_field("packet_dropped", int'(e.packet_dropped), int'(tu[1]));
  endfunction
endclass

module tb_top;

  localparam int CYCLE_LIMIT = 1000000;

  logic                                  clk_i;
  logic                                  rst_ni;
  logic                                  s_axis_tvalid;
  logic                                  s_axis_tready;
  logic [ps2mct_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata;
  logic                                  s_axis_tuser;
  logic                                  m_axis_tvalid;
  logic                                  m_axis_tready;
  logic [ps2mct_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata;
  logic [ps2mct_pkg::OUT_TUSER_BITS-1:0] m_axis_tuser;
  logic                                  cfg_valid_i;
  logic                                  cfg_ready_o;
  logic [ps2mct_pkg::CFG_ADDR_BITS-1:0]  cfg_addr_i;
  logic [ps2mct_pkg::REG_BITS-1:0]       cfg_data_i;

  cursor_scoreboard sb;
  int               cycles;
  int               counted;
  int               hold_len;
  bit               idle_on;

  ps2_mouse_cursor_tracker u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata, m_axis_tuser);
    end
  end

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [8:0] pick_delta();
    int d;
    if ($urandom_range(0, 1) == 0) begin
      d = int'($urandom_range(0, 16)) - 8;
      return d[8:0];
    end
    return 9'($urandom_range(0, 511));
  endfunction

  // receiver: random stalls plus a long hold-off on request
  initial begin
    int stall;
    int held;
    m_axis_tready = 1'b0;
    stall = 0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_len > 0) begin
        held = hold_len;
        hold_len = 0;
        m_axis_tready <= 1'b0;
        repeat (held - 1) @(negedge clk_i);
      end else if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        stall = pick_gap();
        m_axis_tready <= (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  task automatic send_item(logic kind, logic [7:0] b, logic aux,
                           logic [11:0] nx, logic [11:0] ny);
    ps2mct_pkg::item_t it;
    int                gap;
    it.kind      = kind;
    it.data_byte = b;
    it.from_aux  = aux;
    it.new_x     = nx;
    it.new_y     = ny;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.kind;
    s_axis_tdata  <= {7'd0, it.new_y, it.new_x, it.from_aux, it.data_byte};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_item(it);
    counted++;
  endtask

  task automatic send_byte(logic aux, logic [7:0] b);
    send_item(1'b0, b, aux, 12'($urandom), 12'($urandom));
  endtask

  task automatic set_cursor(logic [11:0] nx, logic [11:0] ny);
    send_item(1'b1, 8'($urandom), 1'($urandom), nx, ny);
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(ps2mct_pkg::cfg_reg_e r, int v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= r;
    cfg_data_i  <= v[11:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(r, v[11:0]);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_bounds(int xlo, int xhi, int ylo, int yhi);
    drain();
    cfg_write(ps2mct_pkg::REG_X_MIN, xlo);
    cfg_write(ps2mct_pkg::REG_X_MAX, xhi);
    cfg_write(ps2mct_pkg::REG_Y_MIN, ylo);
    cfg_write(ps2mct_pkg::REG_Y_MAX, yhi);
  endtask

  task automatic maybe_noise();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      send_byte(1'b0, 8'($urandom));
    end else if (r < 11) begin
      set_cursor(12'($urandom), 12'($urandom));
    end
  endtask

  task automatic send_packet();
    logic [8:0] dx;
    logic [8:0] dy;
    logic [1:0] ovf;
    logic [7:0] flags;
    dx = pick_delta();
    dy = pick_delta();
    ovf = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(1, 3)) : 2'b00;
    flags = {ovf[1], ovf[0], dy[8], dx[8], 1'b1, 3'($urandom)};
    send_byte(1'b1, flags);
    maybe_noise();
    send_byte(1'b1, dx[7:0]);
    maybe_noise();
    send_byte(1'b1, dy[7:0]);
  endtask

  task automatic random_traffic(int n);
    int goal;
    int r;
    goal = counted + n;
    while (counted < goal) begin
      r = $urandom_range(0, 99);
      if (r < 72) begin
        send_packet();
      end else if (r < 82) begin
        set_cursor(12'($urandom), 12'($urandom));
      end else if (r < 92) begin
        send_byte(1'b1, 8'($urandom));
      end else begin
        send_byte(1'b0, 8'($urandom));
      end
    end
  endtask

  initial begin
    int xlo;
    int ylo;
    sb = new();
    cycles        = 0;
    counted       = 0;
    hold_len      = 0;
    idle_on       = 1'b1;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_addr_i    = ps2mct_pkg::REG_X_MIN;
    cfg_data_i    = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset bounds 0..79 and 0..24
    send_byte(1'b0, 8'hFF);
    send_byte(1'b1, 8'h00);
    send_byte(1'b1, 8'hF7);
    send_byte(1'b1, 8'h0F);
    send_byte(1'b1, 8'hFF);
    send_byte(1'b1, 8'hFF);
    send_byte(1'b1, 8'h38);
    send_byte(1'b1, 8'h00);
    send_byte(1'b1, 8'h00);
    send_byte(1'b1, 8'h48);
    send_byte(1'b1, 8'h01);
    send_byte(1'b1, 8'h01);
    send_byte(1'b1, 8'hF8);
    send_byte(1'b1, 8'hFF);
    send_byte(1'b1, 8'hFF);
    send_byte(1'b1, 8'h89);
    send_byte(1'b0, 8'h08);
    send_byte(1'b1, 8'h01);
    set_cursor(12'hFFF, 12'hFFF);
    send_byte(1'b1, 8'h02);
    set_cursor(12'h000, 12'h000);
    send_byte(1'b1, 8'h0A);
    send_byte(1'b1, 8'h05);
    send_byte(1'b1, 8'hFB);
    random_traffic(380);

    // full range, with a long receiver hold-off
    set_bounds(0, 4095, 0, 4095);
    set_cursor(12'd2048, 12'd2048);
    hold_len = 300;
    random_traffic(60);
    random_traffic(340);

    // inverted bounds: every clamp lands on the maximum
    set_bounds(3000, 100, 4095, 0);
    random_traffic(300);

    // single-point bounds at opposite corners
    set_bounds(4095, 4095, 0, 0);
    random_traffic(150);
    set_bounds(0, 0, 4095, 4095);
    random_traffic(100);

    // random bounds, with a stretch of back-to-back traffic
    xlo = $urandom_range(0, 3000);
    ylo = $urandom_range(0, 3000);
    set_bounds(xlo, xlo + $urandom_range(0, 1095), ylo, ylo + $urandom_range(0, 1095));
    set_cursor(12'($urandom), 12'($urandom));
    idle_on = 1'b0;
    random_traffic(300);
    idle_on = 1'b1;
    drain();
    random_traffic(300);

    drain();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
